### design/svg_pkg.sv
// Package for the sphere voxel grid block: geometry constants, config indexes, op codes.
// No dependencies; svg_sqrt and the top level import it.
`default_nettype none
package svg_pkg;
  localparam int GridDim = 64;
  localparam int AxW = $clog2(GridDim);
  localparam int AddrW = 3 * AxW;
  localparam int Depth = GridDim * GridDim * GridDim;
  localparam int RadiusScale = 2;
  localparam int MarkReach = 3 * RadiusScale + 1;
  localparam int SearchStart = 10;
  localparam int SearchStep = 10;
  localparam int SearchLimit = 50;
  localparam logic [31:0] CutoffSq = 32'd256000000;

  typedef logic [1:0] op_t;
  localparam op_t OpClear = 2'd0;
  localparam op_t OpMark = 2'd1;
  localparam op_t OpQuery = 2'd2;
  localparam op_t OpNop = 2'd3;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CfgOrgX = 3'd0;
  localparam cfg_idx_t CfgOrgY = 3'd1;
  localparam cfg_idx_t CfgOrgZ = 3'd2;
  localparam cfg_idx_t CfgCellX = 3'd3;
  localparam cfg_idx_t CfgCellY = 3'd4;
  localparam cfg_idx_t CfgCellZ = 3'd5;

  typedef struct packed {
    op_t op;
    logic signed [15:0] atom_x;
    logic signed [15:0] atom_y;
    logic signed [15:0] atom_z;
    logic [7:0] radius;
  } in_word_t;

  typedef struct packed {
    logic [15:0] distance;
    logic status;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic [31:0] value;
  } sqrt_ctl_t;
endpackage
`default_nettype wire

### design/svg_if.sv
// Valid/ready channel interface carrying one word of type T.
// No dependencies; the word type is given by the parameter T.
`default_nettype none
interface svg_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### design/svg_sqrt.sv
// Bit-serial integer square root, one result bit per cycle, 16 result bits.
// Depends on svg_pkg.
`default_nettype none
module svg_sqrt (
  input wire logic clk,
  input wire logic rst,
  input wire svg_pkg::sqrt_ctl_t ctl,
  output logic busy,
  output logic [15:0] root
);
  import svg_pkg::*;
  logic [31:0] rem;
  logic [15:0] res;
  logic [4:0] cnt;
  logic [17:0] trial;

  always_comb begin
    trial = {res, 2'b01};
  end

  logic [33:0] acc;
  logic [33:0] acc_next;
  always_comb begin
    acc_next = {acc[31:0], rem[31:30]};
    if (acc_next >= {16'd0, trial}) begin
      acc_next = acc_next - {16'd0, trial};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      rem <= ctl.value;
      acc <= '0;
      res <= '0;
      cnt <= 5'd16;
    end else if (busy) begin
      acc <= acc_next;
      res <= {res[14:0], ({acc[31:0], rem[31:30]} >= {16'd0, trial})};
      rem <= {rem[29:0], 2'b00};
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end
  assign root = res;
endmodule
`default_nettype wire

### design/sphere_voxel_grid_surface_distance.sv
// Top level of the sphere voxel grid: occupancy memory, mark / query / clear sequencer.
// Depends on svg_pkg, svg_if and svg_sqrt.
//
// Usage: one input word (op, atom position, radius) enters on in_ch; exactly one
// result word (distance, status) leaves on out_ch for each. Config registers are
// written through cfg_we / cfg_index / cfg_data; the user must write them only
// while the block is idle; the block itself does not enforce it. The occupancy
// bits sit in a one-port-read, one-port-write synchronous memory of GridDim^3
// bits. Every voxel visit is a read (S_RD), then a compare or write back
// (S_EVAL), so a mark visits a box of at most 14^3 voxels, a query visits the
// voxels of each box searched (the grid clips a box to at most 64^3 voxels) and
// then runs the square root, and a clear writes zero to each of the GridDim^3 voxels.
// After reset the block runs that same clearing pass; it may accept one word
// meanwhile, but starts that word only once the pass is over.
// One item is in work at a time. The result is held in an output register; while
// the receiver stalls the next input word may be accepted, but its work starts
// only once the previous result has been taken.
`default_nettype none
module sphere_voxel_grid_surface_distance (
  input wire logic clk,
  input wire logic rst,
  svg_if.sink in_ch,
  svg_if.source out_ch,
  input wire logic cfg_we,
  input wire logic [2:0] cfg_index,
  input wire logic [15:0] cfg_data
);
  import svg_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_BOX, S_RD, S_EVAL, S_NEXT, S_SQRT, S_SQW, S_DONE
  } state_t;
  state_t state;

  logic signed [15:0] org [3];
  logic [6:0] ncell [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0; org[1] <= '0; org[2] <= '0;
      ncell[0] <= 7'd64; ncell[1] <= 7'd64; ncell[2] <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgOrgX: org[0] <= cfg_data;
        CfgOrgY: org[1] <= cfg_data;
        CfgOrgZ: org[2] <= cfg_data;
        CfgCellX: ncell[0] <= cfg_data[6:0];
        CfgCellY: ncell[1] <= cfg_data[6:0];
        CfgCellZ: ncell[2] <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Occupancy memory.
  logic mem [Depth];
  logic mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic mem_wdata, mem_rdata;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  in_word_t item;
  logic item_full;
  out_word_t res;
  logic res_valid;

  assign in_ch.ready = !item_full;
  assign out_ch.valid = res_valid;
  assign out_ch.data = res;

  // Per-axis walk: cell of atom, clipped range, current index.
  logic signed [17:0] ctr [3];
  logic signed [17:0] lo [3];
  logic signed [17:0] hi [3];
  logic signed [17:0] cur [3];
  logic [6:0] half;
  logic signed [17:0] half_s;
  logic found;
  logic [31:0] best;
  logic [AddrW:0] clr_cnt;
  logic signed [20:0] dlt [3];
  logic [40:0] sq [3];
  logic [42:0] dsum;
  logic [17:0] thr;
  logic [35:0] thr2;
  logic [7:0] used [3];
  logic signed [17:0] used_s [3];
  logic is_mark;
  sqrt_ctl_t sq_ctl;
  logic sq_busy;
  logic [15:0] sq_root;

  svg_sqrt u_sqrt (.clk(clk), .rst(rst), .ctl(sq_ctl), .busy(sq_busy), .root(sq_root));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      used[a] = (ncell[a] > 7'(GridDim)) ? 8'(GridDim) : {1'b0, ncell[a]};
      used_s[a] = $signed({10'd0, used[a]});
    end
  end
  assign half_s = $signed({11'd0, half});

  // Squared distance: one product per axis in the read cycle, registered before summing.
  logic signed [15:0] atom [3];
  assign atom[0] = item.atom_x;
  assign atom[1] = item.atom_y;
  assign atom[2] = item.atom_z;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dlt[a] = 21'(atom[a]) - 21'(org[a]) - 21'(cur[a] <<< 4);
    end
  end
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) sq[a] <= 41'(dlt[a] * dlt[a]);
  end
  assign dsum = 43'(sq[0]) + 43'(sq[1]) + 43'(sq[2]);
  assign thr = 18'(item.radius) * 18'(RadiusScale);
  assign thr2 = 36'(thr) * 36'(thr);

  assign mem_raddr = {cur[0][AxW-1:0], cur[1][AxW-1:0], cur[2][AxW-1:0]};
  assign is_mark = (item.op == OpMark);

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = mem_raddr;
    mem_wdata = 1'b0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = clr_cnt[AddrW-1:0];
    end else if (state == S_EVAL && is_mark && (43'(thr2) > dsum)) begin
      mem_we = 1'b1;
      mem_wdata = 1'b1;
    end
  end

  logic last_z, last_y, last_x;
  assign last_z = (cur[2] + 18'sd1 >= hi[2]);
  assign last_y = (cur[1] + 18'sd1 >= hi[1]);
  assign last_x = (cur[0] + 18'sd1 >= hi[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      item_full <= 1'b0;
      res_valid <= 1'b0;
      sq_ctl <= '0;
    end else begin
      sq_ctl.start <= 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        item <= in_ch.data;
        item_full <= 1'b1;
      end
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AddrW+1)'(Depth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (item_full && !res_valid) begin
            case (item.op)
              OpClear: begin
                clr_cnt <= '0;
                state <= S_CLEAR;
                item_full <= 1'b0;
                res <= '0;
                res_valid <= 1'b1;
              end
              OpMark, OpQuery: begin
                for (int a = 0; a < 3; a++) begin
                  ctr[a] <= (18'(atom[a]) - 18'(org[a])) >>> 4;
                end
                half <= (item.op == OpMark) ? 7'(MarkReach) : 7'(SearchStart);
                found <= 1'b0;
                state <= S_SETUP;
              end
              default: begin
                item_full <= 1'b0;
                res <= '0;
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_SETUP: begin
          for (int a = 0; a < 3; a++) begin
            lo[a] <= (ctr[a] - half_s < 18'sd0) ? 18'sd0 : ctr[a] - half_s;
            hi[a] <= (ctr[a] + half_s > used_s[a]) ? used_s[a] : ctr[a] + half_s;
          end
          state <= S_BOX;
        end
        S_BOX: begin
          for (int a = 0; a < 3; a++) cur[a] <= lo[a];
          if (lo[0] >= hi[0] || lo[1] >= hi[1] || lo[2] >= hi[2]) state <= S_NEXT;
          else state <= S_RD;
        end
        S_RD: state <= S_EVAL;
        S_EVAL: begin
          if (!is_mark && !mem_rdata) begin
            if (!found || dsum < 43'(best)) begin
              best <= (dsum > 43'hFFFFFFFF) ? 32'hFFFFFFFF : dsum[31:0];
              found <= 1'b1;
            end
          end
          state <= S_RD;
          if (!last_z) cur[2] <= cur[2] + 18'sd1;
          else begin
            cur[2] <= lo[2];
            if (!last_y) cur[1] <= cur[1] + 18'sd1;
            else begin
              cur[1] <= lo[1];
              if (!last_x) cur[0] <= cur[0] + 18'sd1;
              else state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (is_mark) begin
            item_full <= 1'b0;
            res <= '0;
            res_valid <= 1'b1;
            state <= S_IDLE;
          end else if (found && best <= CutoffSq) begin
            sq_ctl.start <= 1'b1;
            sq_ctl.value <= best;
            state <= S_SQRT;
          end else if (32'(half) + 32'(SearchStep) <= 32'(SearchLimit)) begin
            half <= half + 7'(SearchStep);
            found <= 1'b0;
            state <= S_SETUP;
          end else begin
            item_full <= 1'b0;
            res.distance <= '0;
            res.status <= 1'b1;
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SQRT: state <= S_SQW;
        S_SQW: begin
          if (!sq_busy) begin
            item_full <= 1'b0;
            res.distance <= sq_root;
            res.status <= 1'b0;
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/svg_checker.sv
// Port-level checker for the sphere voxel grid block, bound to the top level.
// No dependencies.
`default_nettype none
module svg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [15:0] distance,
  input wire logic status
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(status))
    else $error("result word changed while stalled");
  a_status_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> distance == 16'd0)
    else $error("not-found result with nonzero distance");
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_ready)
    else $error("input not ready right after reset");
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result word right after reset");
endmodule

bind sphere_voxel_grid_surface_distance svg_checker u_svg_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .distance(out_ch.data.distance), .status(out_ch.data.status)
);
`default_nettype wire
